>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, all clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

>>> hw/rtl/cph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cph_pkg
// Types, codes and constants of the color palette hash table.
// ----------------------------------------------------------------------------
package cph_pkg;

	localparam int OP_W     = 2;
	localparam int COLOR_W  = 24;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 9;
	localparam int BUCKETS  = 4096;
	localparam int BUCKET_W = 12;

	localparam logic [INDEX_W-1:0] MAX_COLORS = 9'd256;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [COLOR_W-1:0] color;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                rd_en;
		logic [BUCKET_W-1:0] rd_addr;
		logic                wr_en;
		logic [BUCKET_W-1:0] wr_addr;
		entry_t              wr_data;
	} mem_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_SWEEP
	} state_t;

	function automatic logic [BUCKET_W-1:0] home_bucket(input logic [COLOR_W-1:0] color);
		return color[COLOR_W-1:BUCKET_W] ^ color[BUCKET_W-1:0];
	endfunction

endpackage

>>> hw/rtl/cph_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cph_req_if / cph_rsp_if
// Valid/ready channels for palette requests and their results.
// ----------------------------------------------------------------------------
interface cph_req_if;
	logic                         valid;
	logic                         ready;
	logic [cph_pkg::OP_W-1:0]     operation;
	logic [cph_pkg::COLOR_W-1:0]  color;

	modport source (output valid, output operation, output color, input ready);
	modport sink (input valid, input operation, input color, output ready);
endinterface

interface cph_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cph_pkg::STATUS_W-1:0]  status;
	logic [cph_pkg::INDEX_W-1:0]   palette_index;
	logic [cph_pkg::COLOR_W-1:0]   color_echo;

	modport source (output valid, output status, output palette_index, output color_echo,
		input ready);
	modport sink (input valid, input status, input palette_index, input color_echo,
		output ready);
endinterface

>>> hw/rtl/cph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/cph_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cph_ctrl
// Probe sequencer: linear probing over the bucket RAM, insert, find, clear
// sweep, palette counter and the result register.
// ----------------------------------------------------------------------------
module cph_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	cph_req_if.sink                       req,
	cph_rsp_if.source                     rsp,
	output cph_pkg::mem_req_t             mem,
	input  logic [cph_pkg::ENTRY_W-1:0]   rd_data
);

	cph_pkg::state_t                   state_q, state_d;
	logic [cph_pkg::OP_W-1:0]          op_q;
	logic [cph_pkg::COLOR_W-1:0]       color_q;
	logic [cph_pkg::BUCKET_W-1:0]      addr_q;
	logic [cph_pkg::BUCKET_W-1:0]      sweep_q;
	logic                              report_q;
	logic [cph_pkg::INDEX_W-1:0]       cnt_q;
	logic                              full_q;
	logic                              out_valid_q;
	logic [cph_pkg::STATUS_W-1:0]      out_status_q;
	logic [cph_pkg::INDEX_W-1:0]       out_index_q;
	logic [cph_pkg::COLOR_W-1:0]       out_color_q;

	cph_pkg::entry_t                   entry;
	logic                              empty;
	logic                              hit;
	logic                              probe_end;
	logic                              sweep_last;
	logic                              out_free;
	logic                              accept;
	logic                              addr_adv;
	logic                              cnt_inc;
	logic                              full_set;
	logic                              res_load;
	logic [cph_pkg::STATUS_W-1:0]      res_status;
	logic [cph_pkg::INDEX_W-1:0]       res_index;
	logic [cph_pkg::COLOR_W-1:0]       res_color;

	assign entry      = cph_pkg::entry_t'(rd_data);
	assign empty      = (entry.index == '0);
	assign hit        = !empty && (entry.color == color_q);
	assign probe_end  = full_q || hit || empty;
	assign sweep_last = (sweep_q == cph_pkg::BUCKET_W'(cph_pkg::BUCKETS - 1));
	assign out_free   = !out_valid_q || rsp.ready;
	assign accept     = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cph_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = (req.operation == cph_pkg::OP_CLEAR) ? cph_pkg::S_SWEEP
						: cph_pkg::S_PROBE;
				end
			end
			cph_pkg::S_PROBE: begin
				if (probe_end && out_free) begin
					state_d = cph_pkg::S_IDLE;
				end
			end
			cph_pkg::S_SWEEP: begin
				if (sweep_last && (!report_q || out_free)) begin
					state_d = cph_pkg::S_IDLE;
				end
			end
			default: state_d = cph_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem        = '0;
		req.ready  = 1'b0;
		addr_adv   = 1'b0;
		cnt_inc    = 1'b0;
		full_set   = 1'b0;
		res_load   = 1'b0;
		res_status = cph_pkg::ST_MISSING;
		res_index  = '0;
		res_color  = color_q;
		case (state_q)
			cph_pkg::S_IDLE: begin
				req.ready   = 1'b1;
				mem.rd_en   = req.valid && (req.operation != cph_pkg::OP_CLEAR);
				mem.rd_addr = cph_pkg::home_bucket(req.color);
			end
			cph_pkg::S_PROBE: begin
				if (!probe_end) begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = addr_q + 1'b1;
					addr_adv    = 1'b1;
				end else if (out_free) begin
					res_load = 1'b1;
					if (full_q) begin
						res_status = cph_pkg::ST_FULL;
					end else if (hit) begin
						res_status = cph_pkg::ST_PRESENT;
						res_index  = entry.index;
					end else if (op_q == cph_pkg::OP_INSERT) begin
						if (cnt_q >= cph_pkg::MAX_COLORS) begin
							full_set   = 1'b1;
							res_status = cph_pkg::ST_FULL;
						end else begin
							cnt_inc             = 1'b1;
							mem.wr_en           = 1'b1;
							mem.wr_addr         = addr_q;
							mem.wr_data.index   = cnt_q + 1'b1;
							mem.wr_data.color   = color_q;
							res_status          = cph_pkg::ST_ADDED;
							res_index           = cnt_q + 1'b1;
						end
					end else begin
						res_status = cph_pkg::ST_MISSING;
					end
				end
			end
			cph_pkg::S_SWEEP: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = sweep_q;
				if (sweep_last && report_q && out_free) begin
					res_load   = 1'b1;
					res_status = cph_pkg::ST_CLEARED;
					res_color  = '0;
				end
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cph_pkg::S_SWEEP;
			sweep_q     <= '0;
			report_q    <= 1'b0;
			cnt_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (req.operation == cph_pkg::OP_CLEAR)) begin
				sweep_q  <= '0;
				report_q <= 1'b1;
				cnt_q    <= '0;
				full_q   <= 1'b0;
			end else begin
				if ((state_q == cph_pkg::S_SWEEP) && !sweep_last) begin
					sweep_q <= sweep_q + 1'b1;
				end
				if (cnt_inc) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (full_set) begin
					full_q <= 1'b1;
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			color_q <= req.color;
			addr_q  <= cph_pkg::home_bucket(req.color);
		end else if (addr_adv) begin
			addr_q <= addr_q + 1'b1;
		end
		if (res_load) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_color_q  <= res_color;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.palette_index = out_index_q;
	assign rsp.color_echo    = out_color_q;

	`ASSERT_NEVER(a_no_rw_same_bucket, clk, arst_n,
		mem.wr_en && mem.rd_en && (mem.wr_addr == mem.rd_addr))
	`ASSERT_AT(a_count_bounded, clk, arst_n, cnt_q <= cph_pkg::MAX_COLORS)
	`ASSERT_AT(a_full_at_limit, clk, arst_n, full_q |-> (cnt_q == cph_pkg::MAX_COLORS))
	`ASSERT_AT(a_clear_sweeps, clk, arst_n,
		(accept && (req.operation == cph_pkg::OP_CLEAR)) |=> (state_q == cph_pkg::S_SWEEP))

endmodule

>>> hw/rtl/color_palette_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_palette_hash_table
// Palette of up to 256 colors in a 4096-bucket open-addressing table with
// linear probing.
// ----------------------------------------------------------------------------
// Channel  Role  Payload
// req      sink  operation[1:0], color[23:0]
// rsp      src   status[2:0], palette_index[8:0], color_echo[23:0]
//
// Insert and find read the home bucket, then each following bucket in turn,
// until a hit, an empty bucket or a full palette ends the probe; the single
// read port of the bucket RAM reads one bucket at a time. Clear writes every
// bucket in turn; after reset the same sweep runs before the first request.
// A stalled result waits in the output register; the probe holds meanwhile.
// ----------------------------------------------------------------------------
module color_palette_hash_table (
	input  logic       clk,
	input  logic       arst_n,
	cph_req_if.sink    req,
	cph_rsp_if.source  rsp
);

	cph_pkg::mem_req_t               mem;
	logic [cph_pkg::ENTRY_W-1:0]     rd_data;

	cph_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem     (mem),
		.rd_data (rd_data)
	);

	cph_ram #(
		.WIDTH (cph_pkg::ENTRY_W),
		.DEPTH (cph_pkg::BUCKETS)
	) u_bucket_ram (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);

endmodule
